// ----- src/tbd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbd_pkg
// Shared types, codes and frame decode helpers for the tape block deframer.
// ----------------------------------------------------------------------------
package tbd_pkg;

   // width of the saturating leader counter
   localparam int LC_BITS = 16;

   // depth of the front-to-back queue
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

   // tape codes (octal)
   localparam logic [7:0] CODE_SOH = 8'o201;
   localparam logic [7:0] CODE_ETX = 8'o203;
   localparam logic [7:0] CODE_DC3 = 8'o223;
   localparam logic [7:0] CODE_DEL = 8'o377;

   // channel masks
   localparam logic [7:0] MASK_FIRST = 8'o017;
   localparam logic [7:0] MASK_REST  = 8'o237;

   // result kinds
   localparam logic [2:0] KIND_DATA  = 3'd0;
   localparam logic [2:0] KIND_GOOD  = 3'd1;
   localparam logic [2:0] KIND_MARK  = 3'd2;
   localparam logic [2:0] KIND_ERROR = 3'd3;
   localparam logic [2:0] KIND_CLEAN = 3'd4;

   // error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_EARLY    = 3'd1;
   localparam logic [2:0] ERR_NO_START = 3'd2;
   localparam logic [2:0] ERR_CHANNEL  = 3'd3;
   localparam logic [2:0] ERR_DC3      = 3'd4;
   localparam logic [2:0] ERR_NO_DEL   = 3'd5;
   localparam logic [2:0] ERR_CHECKSUM = 3'd6;

   // one classified frame, as queued between front and back
   typedef struct packed {
      logic       stream_end;
      logic       is_zero;
      logic       is_soh;
      logic       is_etx;
      logic       is_dc3;
      logic       is_del;
      logic       ok_first;   // no punched channel outside first-frame mask
      logic       ok_rest;    // no punched channel outside later-frame mask
      logic [5:0] six;        // decoded six bits
   } frame_type;

endpackage

// ----- src/tbd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbd_front
// Classifies an incoming tape frame: control codes, channel checks and the
// six-bit decode with the 0174..0177 remap.
// ----------------------------------------------------------------------------
module tbd_front import tbd_pkg::*; (
   input  logic [7:0] tape_byte,
   input  logic       stream_end,
   output frame_type  frame
);

   logic [6:0] l7;
   logic       remapped;

   always_comb begin
      remapped = 1'b1;
      case (tape_byte[6:0])
         7'o174:  l7 = 7'o005;
         7'o175:  l7 = 7'o012;
         7'o176:  l7 = 7'o021;
         7'o177:  l7 = 7'o023;
         default: begin
            l7       = tape_byte[6:0];
            remapped = 1'b0;
         end
      endcase

      frame.stream_end = stream_end;
      frame.is_zero    = (tape_byte == 8'd0);
      frame.is_soh     = (tape_byte == CODE_SOH);
      frame.is_etx     = (tape_byte == CODE_ETX);
      frame.is_dc3     = (tape_byte == CODE_DC3);
      frame.is_del     = (tape_byte == CODE_DEL);
      frame.ok_first   = remapped || ((tape_byte & ~MASK_FIRST) == 8'd0);
      frame.ok_rest    = remapped || ((tape_byte & ~MASK_REST) == 8'd0);
      frame.six        = {tape_byte[7], l7[4:0]};
   end

endmodule

// ----- src/tbd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbd_queue
// Short FIFO of classified frames between the front and the back.
// ----------------------------------------------------------------------------
module tbd_queue import tbd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  frame_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output frame_type pop_data
);

   frame_type                 mem_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_BITS:0]       count_ff, count_in;
   logic                      do_push, do_pop;

   assign full      = (count_ff == (Q_PTR_BITS+1)'(Q_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/tbd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbd_back
// Block state machine: leader counting, start codes, word assembly,
// checksum and trailer checks, with a registered result stage.
// ----------------------------------------------------------------------------
module tbd_back import tbd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        frame_valid,
   input  frame_type   frame,
   output logic        frame_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_result_kind,
   output logic [2:0]  rsp_error_code,
   output logic [17:0] rsp_data_word,
   output logic [15:0] rsp_leader_count
);

   localparam logic [2:0] PH_LEADER = 3'd0;
   localparam logic [2:0] PH_ETX1   = 3'd1;
   localparam logic [2:0] PH_ETX2   = 3'd2;
   localparam logic [2:0] PH_W0     = 3'd3;
   localparam logic [2:0] PH_W1     = 3'd4;
   localparam logic [2:0] PH_W2     = 3'd5;
   localparam logic [2:0] PH_FIN    = 3'd6;

   localparam int LC_EXT = (LC_BITS > 16) ? LC_BITS : 16;

   logic [2:0]         phase_ff, phase_in;
   logic [LC_BITS-1:0] leader_ff, leader_in;
   logic [11:0]        partial_ff, partial_in;
   logic [17:0]        csum_ff, csum_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         kind_ff, kind_in;
   logic [2:0]         err_ff, err_in;
   logic [17:0]        word_ff, word_in;
   logic [15:0]        lc_ff, lc_in;

   logic               res_v;
   logic               do_finish;
   logic [17:0]        full_word;
   logic [LC_EXT-1:0]  leader_ext;

   assign frame_pop = frame_valid && (!rsp_valid_ff || rsp_ready);
   assign full_word = {partial_ff, frame.six};
   assign leader_ext = LC_EXT'(leader_ff);

   always_comb begin
      phase_in   = phase_ff;
      leader_in  = leader_ff;
      partial_in = partial_ff;
      csum_in    = csum_ff;
      res_v      = 1'b0;
      do_finish  = 1'b0;
      kind_in    = KIND_DATA;
      err_in     = ERR_NONE;
      word_in    = '0;
      // count before any clearing by this frame
      lc_in      = (leader_ext > LC_EXT'(16'hFFFF)) ? 16'hFFFF : leader_ext[15:0];

      case (phase_ff)
         PH_ETX1: begin
            if (frame.stream_end || !frame.is_dc3) begin
               res_v = 1'b1; kind_in = KIND_ERROR; err_in = ERR_NO_START;
               do_finish = 1'b1;
            end else begin
               phase_in = PH_ETX2;
            end
         end
         PH_ETX2: begin
            res_v     = 1'b1;
            do_finish = 1'b1;
            if (frame.stream_end || !frame.is_del) begin
               kind_in = KIND_ERROR; err_in = ERR_NO_START;
            end else begin
               kind_in = KIND_MARK;
            end
         end
         PH_W0: begin
            if (frame.stream_end) begin
               res_v = 1'b1; kind_in = KIND_ERROR; err_in = ERR_EARLY;
               do_finish = 1'b1;
            end else if (frame.is_dc3) begin
               phase_in = PH_FIN;
            end else if (!frame.ok_first) begin
               res_v = 1'b1; kind_in = KIND_ERROR; err_in = ERR_CHANNEL;
               do_finish = 1'b1;
            end else begin
               partial_in = {6'd0, frame.six};
               phase_in   = PH_W1;
            end
         end
         PH_W1, PH_W2: begin
            if (frame.stream_end) begin
               res_v = 1'b1; kind_in = KIND_ERROR; err_in = ERR_EARLY;
               do_finish = 1'b1;
            end else if (frame.is_dc3) begin
               res_v = 1'b1; kind_in = KIND_ERROR; err_in = ERR_DC3;
               do_finish = 1'b1;
            end else if (!frame.ok_rest) begin
               res_v = 1'b1; kind_in = KIND_ERROR; err_in = ERR_CHANNEL;
               do_finish = 1'b1;
            end else if (phase_ff == PH_W1) begin
               partial_in = {partial_ff[5:0], frame.six};
               phase_in   = PH_W2;
            end else begin
               csum_in    = csum_ff ^ full_word;
               partial_in = '0;
               phase_in   = PH_W0;
               res_v      = 1'b1;
               kind_in    = KIND_DATA;
               word_in    = full_word;
            end
         end
         PH_FIN: begin
            res_v     = 1'b1;
            do_finish = 1'b1;
            kind_in   = KIND_ERROR;
            if (frame.stream_end)    err_in = ERR_EARLY;
            else if (!frame.is_del)  err_in = ERR_NO_DEL;
            else if (csum_ff != '0)  err_in = ERR_CHECKSUM;
            else                     kind_in = KIND_GOOD;
         end
         default: begin
            // leader hunt; unknown codes fall in here as well
            phase_in = PH_LEADER;
            if (frame.stream_end) begin
               res_v = 1'b1; kind_in = KIND_CLEAN; do_finish = 1'b1;
            end else if (frame.is_zero) begin
               if (leader_ff != '1) leader_in = leader_ff + 1'b1;
            end else if (frame.is_soh) begin
               csum_in    = '0;
               partial_in = '0;
               phase_in   = PH_W0;
            end else if (frame.is_etx) begin
               phase_in = PH_ETX1;
            end else begin
               res_v = 1'b1; kind_in = KIND_ERROR; err_in = ERR_NO_START;
               do_finish = 1'b1;
            end
         end
      endcase

      if (do_finish) begin
         phase_in   = PH_LEADER;
         leader_in  = '0;
         partial_in = '0;
         csum_in    = '0;
      end

      if (frame_pop && res_v) rsp_valid_in = 1'b1;
      else if (rsp_ready)     rsp_valid_in = 1'b0;
      else                    rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEADER;
         leader_ff    <= '0;
         partial_ff   <= '0;
         csum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (frame_pop) begin
            phase_ff   <= phase_in;
            leader_ff  <= leader_in;
            partial_ff <= partial_in;
            csum_ff    <= csum_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_pop && res_v) begin
         kind_ff <= kind_in;
         err_ff  <= err_in;
         word_ff <= word_in;
         lc_ff   <= lc_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_error_code   = err_ff;
   assign rsp_data_word    = word_ff;
   assign rsp_leader_count = lc_ff;

endmodule

// ----- src/tape_block_deframer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_block_deframer_core
// Paper-tape block deframer: one tape frame per request, decoded words and
// block status out.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one eight-channel frame per request (req_tape_byte), or
//    req_stream_end=1 to signal end of tape. valid/ready handshake.
//  - rsp channel: zero or one result per request: data word, block good,
//    end-of-tape mark, error (with code) or clean end, each tagged with the
//    leader frame count seen before the block.
//  - Throughput while rsp_ready is high: one request per cycle; the front
//    classifier is pure logic, the back state machine pops one frame per cycle.
//  - Path: an accepted request is written into the queue, then popped by the
//    back, whose result register drives rsp_valid.
//  - Receiver stall: the result register holds; the back stops popping and
//    the 4-entry queue absorbs requests until full, then req_ready drops.
//  - Reset (synchronous): queue emptied, no result pending, deframer back
//    in leader hunt with counters and checksum cleared.
// ----------------------------------------------------------------------------
module tape_block_deframer_core import tbd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_tape_byte,
   input  logic        req_stream_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_result_kind,
   output logic [2:0]  rsp_error_code,
   output logic [17:0] rsp_data_word,
   output logic [15:0] rsp_leader_count
);

   frame_type front_frame;   // classified request, ready to queue
   frame_type back_frame;    // head of queue
   logic      q_full;
   logic      q_not_empty;
   logic      q_pop;

   // front: classify the frame as it arrives
   tbd_front u_front (
      .tape_byte  (req_tape_byte),
      .stream_end (req_stream_end),
      .frame      (front_frame)
   );

   assign req_ready = !q_full;

   // decoupling queue
   tbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (front_frame),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (back_frame)
   );

   // back: block state machine and result register
   tbd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .frame_valid      (q_not_empty),
      .frame            (back_frame),
      .frame_pop        (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_error_code   (rsp_error_code),
      .rsp_data_word    (rsp_data_word),
      .rsp_leader_count (rsp_leader_count)
   );

endmodule
